// ===== src/nfbm_pkg.sv =====
// ----------------------------------------------------------------------------
// nfbm_pkg
// Shared types and constants of the byte-level NFA full matcher.
// ----------------------------------------------------------------------------
package nfbm_pkg;

	// default sizes of the state table and of the class bitmap store
	localparam int unsigned MAX_NFA_STATES_DEF = 128;
	localparam int unsigned MAX_CLASS_MAPS_DEF = 64;

	// configuration register indexes
	localparam logic [1:0] CFG_START_STATE   = 2'd0;
	localparam logic [1:0] CFG_STATE_COUNT   = 2'd1;
	localparam logic [1:0] CFG_PATTERN_VALID = 2'd2;

	// item kinds carried on tuser
	typedef enum logic [1:0] {
		MODE_LOAD_STATE = 2'd0,
		MODE_LOAD_CLASS = 2'd1,
		MODE_BEGIN      = 2'd2,
		MODE_DATA       = 2'd3
	} mode_t;

	// NFA state kinds
	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_CLASS = 2'd1,
		KIND_SPLIT = 2'd2,
		KIND_MATCH = 2'd3
	} kind_t;

	// one state table entry
	typedef struct packed {
		kind_t      kind;
		logic [7:0] succ1;
		logic [7:0] succ2;
		logic [7:0] byte_val;
		logic [5:0] cref;
		logic       neg;
	} entry_t;

	// source of a successor that is tried for the next set
	typedef enum logic [1:0] {
		ADD_NONE  = 2'd0,
		ADD_START = 2'd1,
		ADD_SUCC1 = 2'd2,
		ADD_SUCC2 = 2'd3
	} add_src_t;

	// address source of a state table read
	typedef enum logic [1:0] {
		TRD_NONE  = 2'd0,
		TRD_INDEX = 2'd1,
		TRD_STACK = 2'd2
	} tbl_src_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_POP,
		ST_POP_WAIT,
		ST_CL_TBL,
		ST_CL_TRY2,
		ST_SCAN,
		ST_SCAN_TBL,
		ST_SCAN_CLS,
		ST_EVAL,
		ST_EVAL_TBL,
		ST_COMMIT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     in_ready;
		logic     clr_nxt;
		add_src_t add_sel;
		logic     pop;
		tbl_src_t tbl_rd;
		logic     cls_rd;
		logic     i_clr;
		logic     i_inc;
		logic     ev_clr;
		logic     ev_alive;
		logic     ev_acc;
		logic     commit;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  in_valid;
		mode_t in_mode;
		mode_t mode_q;
		logic  last_q;
		logic  dead;
		logic  i_done;
		logic  cur_bit;
		logic  nxt_bit;
		logic  sp_zero;
		kind_t kind;
		logic  char_hit;
		logic  cls_hit;
		logic  out_free;
	} status_t;

endpackage

// ===== src/nfa_byte_full_matcher.sv =====
// ----------------------------------------------------------------------------
// nfa_byte_full_matcher
// Byte-level Thompson NFA simulator giving a full-match answer per byte.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ channel; tuser selects load-state, load-class,
// begin or data. Load items are written in the cycle they are accepted and
// give no result. A begin builds the start closure; it gives a result only
// when tlast is set (empty string). Each data byte gives one result on the
// m_ channel: alive, accepting, and tlast echoed.
// Flow: a live data byte scans the active set, walks the closure of each hit
// through the stack and evaluates the next set; a byte on a dead set goes
// straight to an all-zero result. A begin walks the start closure and
// evaluates it. The single read port of the state table is shared by the
// scan and the closure stack. One item is in work at a time.
// Reset clears the sets and marks the matcher dead; table and bitmap contents
// are undefined until loaded. A finished result waits in the output register;
// the next item is accepted meanwhile, and a second result holds the
// sequencer until the first is taken.
// Configuration is to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module nfa_byte_full_matcher #(
	parameter int unsigned MAX_NFA_STATES = nfbm_pkg::MAX_NFA_STATES_DEF,
	parameter int unsigned MAX_CLASS_MAPS = nfbm_pkg::MAX_CLASS_MAPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// index[6:0] state_kind[8:7] succ_first[16:9] succ_second[24:17]
	// byte_value[32:25] class_ref[38:33] negate[39] word_select[41:40]
	// class_bits[105:42], zero fill [111:106]
	input  logic [111:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// alive[0] accepting[1], zero fill [7:2]
	output logic [7:0]   m_tdata,
	output logic         m_tlast
);

	nfbm_pkg::cmd_t    cmd;
	nfbm_pkg::status_t sts;

	assign s_tready = cmd.in_ready;

	nfbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	nfbm_dp #(
		.MAX_NFA_STATES (MAX_NFA_STATES),
		.MAX_CLASS_MAPS (MAX_CLASS_MAPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== src/nfbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfbm_ctrl
// Sequencer: scans the active set, walks closures through the stack and
// evaluates the new set, one table access at a time.
// ----------------------------------------------------------------------------
module nfbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  nfbm_pkg::status_t sts,
	output nfbm_pkg::cmd_t    cmd
);

	nfbm_pkg::state_t state_q, state_d;
	logic ret_scan_q, ret_scan_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nfbm_pkg::ST_IDLE;
			ret_scan_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_scan_q <= ret_scan_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		ret_scan_d = ret_scan_q;
		cmd        = '0;
		cmd.add_sel = nfbm_pkg::ADD_NONE;
		cmd.tbl_rd  = nfbm_pkg::TRD_NONE;
		case (state_q)
			nfbm_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					case (sts.in_mode)
						nfbm_pkg::MODE_BEGIN: begin
							cmd.clr_nxt = 1'b1;
							state_d     = nfbm_pkg::ST_SEED;
						end
						nfbm_pkg::MODE_DATA: begin
							if (sts.dead) begin
								// dead set: result is all zero, set unchanged
								cmd.ev_clr = 1'b1;
								state_d    = nfbm_pkg::ST_OUT;
							end else begin
								cmd.clr_nxt = 1'b1;
								cmd.i_clr   = 1'b1;
								state_d     = nfbm_pkg::ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			nfbm_pkg::ST_SEED: begin
				cmd.add_sel = nfbm_pkg::ADD_START;
				ret_scan_d  = 1'b0;
				state_d     = nfbm_pkg::ST_POP;
			end
			nfbm_pkg::ST_POP: begin
				if (sts.sp_zero) begin
					if (ret_scan_q) begin
						state_d = nfbm_pkg::ST_SCAN;
					end else begin
						cmd.ev_clr = 1'b1;
						cmd.i_clr  = 1'b1;
						state_d    = nfbm_pkg::ST_EVAL;
					end
				end else begin
					cmd.pop = 1'b1;
					state_d = nfbm_pkg::ST_POP_WAIT;
				end
			end
			nfbm_pkg::ST_POP_WAIT: begin
				cmd.tbl_rd = nfbm_pkg::TRD_STACK;
				state_d    = nfbm_pkg::ST_CL_TBL;
			end
			nfbm_pkg::ST_CL_TBL: begin
				if (sts.kind == nfbm_pkg::KIND_SPLIT) begin
					cmd.add_sel = nfbm_pkg::ADD_SUCC1;
					state_d     = nfbm_pkg::ST_CL_TRY2;
				end else begin
					state_d = nfbm_pkg::ST_POP;
				end
			end
			nfbm_pkg::ST_CL_TRY2: begin
				cmd.add_sel = nfbm_pkg::ADD_SUCC2;
				state_d     = nfbm_pkg::ST_POP;
			end
			nfbm_pkg::ST_SCAN: begin
				if (sts.i_done) begin
					cmd.ev_clr = 1'b1;
					cmd.i_clr  = 1'b1;
					state_d    = nfbm_pkg::ST_EVAL;
				end else if (!sts.cur_bit) begin
					cmd.i_inc = 1'b1;
				end else begin
					cmd.tbl_rd = nfbm_pkg::TRD_INDEX;
					state_d    = nfbm_pkg::ST_SCAN_TBL;
				end
			end
			nfbm_pkg::ST_SCAN_TBL: begin
				case (sts.kind)
					nfbm_pkg::KIND_CHAR: begin
						cmd.i_inc = 1'b1;
						if (sts.char_hit) begin
							cmd.add_sel = nfbm_pkg::ADD_SUCC1;
							ret_scan_d  = 1'b1;
							state_d     = nfbm_pkg::ST_POP;
						end else begin
							state_d = nfbm_pkg::ST_SCAN;
						end
					end
					nfbm_pkg::KIND_CLASS: begin
						cmd.cls_rd = 1'b1;
						state_d    = nfbm_pkg::ST_SCAN_CLS;
					end
					default: begin
						cmd.i_inc = 1'b1;
						state_d   = nfbm_pkg::ST_SCAN;
					end
				endcase
			end
			nfbm_pkg::ST_SCAN_CLS: begin
				cmd.i_inc = 1'b1;
				if (sts.cls_hit) begin
					cmd.add_sel = nfbm_pkg::ADD_SUCC1;
					ret_scan_d  = 1'b1;
					state_d     = nfbm_pkg::ST_POP;
				end else begin
					state_d = nfbm_pkg::ST_SCAN;
				end
			end
			nfbm_pkg::ST_EVAL: begin
				if (sts.i_done) begin
					state_d = nfbm_pkg::ST_COMMIT;
				end else if (!sts.nxt_bit) begin
					cmd.i_inc = 1'b1;
				end else begin
					cmd.ev_alive = 1'b1;
					cmd.tbl_rd   = nfbm_pkg::TRD_INDEX;
					state_d      = nfbm_pkg::ST_EVAL_TBL;
				end
			end
			nfbm_pkg::ST_EVAL_TBL: begin
				cmd.ev_acc = 1'b1;
				cmd.i_inc  = 1'b1;
				state_d    = nfbm_pkg::ST_EVAL;
			end
			nfbm_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				if (sts.mode_q == nfbm_pkg::MODE_DATA || sts.last_q) begin
					state_d = nfbm_pkg::ST_OUT;
				end else begin
					state_d = nfbm_pkg::ST_IDLE;
				end
			end
			nfbm_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = nfbm_pkg::ST_IDLE;
				end
			end
			default: state_d = nfbm_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== src/nfbm_dp.sv =====
// ----------------------------------------------------------------------------
// nfbm_dp
// Datapath: configuration, state table, class bitmaps, closure stack,
// active and next state sets, scan index and the result register.
// ----------------------------------------------------------------------------
module nfbm_dp #(
	parameter int unsigned MAX_NFA_STATES = nfbm_pkg::MAX_NFA_STATES_DEF,
	parameter int unsigned MAX_CLASS_MAPS = nfbm_pkg::MAX_CLASS_MAPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_wdata,
	input  logic              s_tvalid,
	input  logic [111:0]      s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	input  nfbm_pkg::cmd_t    cmd,
	output nfbm_pkg::status_t sts
);

	localparam int unsigned SW  = $clog2(MAX_NFA_STATES);
	localparam int unsigned NW  = $clog2(MAX_NFA_STATES + 1);
	localparam int unsigned CAW = $clog2(MAX_CLASS_MAPS * 4);

	// input fields
	logic [6:0]      in_index;
	nfbm_pkg::kind_t in_kind;
	logic [7:0]      in_succ1, in_succ2, in_byte;
	logic [5:0]      in_cref;
	logic            in_neg;
	logic [1:0]      in_word;
	logic [63:0]     in_bits;
	logic            accept;

	assign in_index = s_tdata[6:0];
	assign in_kind  = nfbm_pkg::kind_t'(s_tdata[8:7]);
	assign in_succ1 = s_tdata[16:9];
	assign in_succ2 = s_tdata[24:17];
	assign in_byte  = s_tdata[32:25];
	assign in_cref  = s_tdata[38:33];
	assign in_neg   = s_tdata[39];
	assign in_word  = s_tdata[41:40];
	assign in_bits  = s_tdata[105:42];
	assign accept   = s_tvalid && cmd.in_ready;

	// configuration registers
	logic [6:0] start_q;
	logic [7:0] count_q;
	logic       pvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			count_q  <= '0;
			pvalid_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				nfbm_pkg::CFG_START_STATE:   start_q  <= cfg_wdata[6:0];
				nfbm_pkg::CFG_STATE_COUNT:   count_q  <= cfg_wdata;
				nfbm_pkg::CFG_PATTERN_VALID: pvalid_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective state count
	logic [NW-1:0] n_eff;
	assign n_eff = (32'(count_q) > MAX_NFA_STATES) ? NW'(MAX_NFA_STATES) : NW'(count_q);

	// captured item
	nfbm_pkg::mode_t mode_q;
	logic [7:0]      b_q;
	logic            last_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= nfbm_pkg::mode_t'(s_tuser);
			b_q    <= in_byte;
			last_q <= s_tlast;
		end
	end

	// scan index
	logic [NW-1:0] i_q;
	logic [SW-1:0] i_idx;
	assign i_idx = i_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.i_clr) begin
			i_q <= '0;
		end else if (cmd.i_inc) begin
			i_q <= i_q + NW'(1);
		end
	end

	// state table memory
	nfbm_pkg::entry_t tbl_mem [MAX_NFA_STATES];
	nfbm_pkg::entry_t tbl_q;
	nfbm_pkg::entry_t tbl_wr;
	logic [SW-1:0]    stack_rd_q;
	logic [SW-1:0]    tbl_ra;

	assign tbl_wr = '{kind: in_kind, succ1: in_succ1, succ2: in_succ2, byte_val: in_byte,
		cref: in_cref, neg: in_neg};
	assign tbl_ra = (cmd.tbl_rd == nfbm_pkg::TRD_STACK) ? stack_rd_q : i_idx;

	always_ff @(posedge clk) begin
		if (accept && s_tuser == nfbm_pkg::MODE_LOAD_STATE
				&& 32'(in_index) < MAX_NFA_STATES) begin
			tbl_mem[SW'(in_index)] <= tbl_wr;
		end
		if (cmd.tbl_rd != nfbm_pkg::TRD_NONE) begin
			tbl_q <= tbl_mem[tbl_ra];
		end
	end

	// class bitmap memory
	logic [63:0] cls_mem [MAX_CLASS_MAPS * 4];
	logic [63:0] cls_q;
	logic        cls_ok_q;

	always_ff @(posedge clk) begin
		if (accept && s_tuser == nfbm_pkg::MODE_LOAD_CLASS
				&& 32'(in_index) < MAX_CLASS_MAPS) begin
			cls_mem[CAW'({in_index, in_word})] <= in_bits;
		end
		if (cmd.cls_rd) begin
			cls_q    <= cls_mem[CAW'({tbl_q.cref, b_q[7:6]})];
			cls_ok_q <= 32'(tbl_q.cref) < MAX_CLASS_MAPS;
		end
	end

	// successor chosen for a try-add
	logic [7:0]    add_code;
	logic          add_ok;
	logic [SW-1:0] add_idx;
	logic          add_do;

	always_comb begin
		case (cmd.add_sel)
			nfbm_pkg::ADD_START: add_code = {1'b0, start_q};
			nfbm_pkg::ADD_SUCC1: add_code = tbl_q.succ1;
			nfbm_pkg::ADD_SUCC2: add_code = tbl_q.succ2;
			default:             add_code = '0;
		endcase
	end

	logic [MAX_NFA_STATES-1:0] cur_q, nxt_q;

	assign add_ok  = !add_code[7] && (32'(add_code[6:0]) < 32'(n_eff));
	assign add_idx = SW'(add_code[6:0]);
	assign add_do  = (cmd.add_sel != nfbm_pkg::ADD_NONE) && add_ok && !nxt_q[add_idx];

	// closure stack
	logic [SW-1:0] stack_mem [MAX_NFA_STATES];
	logic [NW-1:0] sp_q;
	logic [NW-1:0] sp_m1;
	assign sp_m1 = sp_q - NW'(1);

	always_ff @(posedge clk) begin
		if (add_do) begin
			stack_mem[sp_q[SW-1:0]] <= add_idx;
		end
		if (cmd.pop) begin
			stack_rd_q <= stack_mem[sp_m1[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (add_do) begin
			sp_q <= sp_q + NW'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_m1;
		end
	end

	// state sets, evaluation flags and dead flag
	logic alive_q, acc_q, dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			nxt_q   <= '0;
			alive_q <= 1'b0;
			acc_q   <= 1'b0;
			dead_q  <= 1'b1;
		end else begin
			if (cmd.clr_nxt) begin
				nxt_q <= '0;
			end else if (add_do) begin
				nxt_q[add_idx] <= 1'b1;
			end
			if (cmd.ev_clr) begin
				alive_q <= 1'b0;
				acc_q   <= 1'b0;
			end else begin
				if (cmd.ev_alive) alive_q <= 1'b1;
				if (cmd.ev_acc && tbl_q.kind == nfbm_pkg::KIND_MATCH) acc_q <= 1'b1;
			end
			if (cmd.commit) begin
				cur_q  <= alive_q ? nxt_q : '0;
				dead_q <= !alive_q;
			end
		end
	end

	// result register
	logic out_valid_q, out_alive_q, out_acc_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_alive_q <= alive_q;
			out_acc_q   <= alive_q && acc_q && pvalid_q;
			out_last_q  <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_acc_q, out_alive_q};
	assign m_tlast  = out_last_q;

	// status to the controller
	always_comb begin
		sts          = '0;
		sts.in_valid = s_tvalid;
		sts.in_mode  = nfbm_pkg::mode_t'(s_tuser);
		sts.mode_q   = mode_q;
		sts.last_q   = last_q;
		sts.dead     = dead_q;
		sts.i_done   = i_q >= n_eff;
		sts.cur_bit  = cur_q[i_idx];
		sts.nxt_bit  = nxt_q[i_idx];
		sts.sp_zero  = sp_q == '0;
		sts.kind     = tbl_q.kind;
		sts.char_hit = tbl_q.byte_val == b_q;
		sts.cls_hit  = (cls_ok_q && cls_q[b_q[5:0]]) != tbl_q.neg;
		sts.out_free = !out_valid_q || m_tready;
	end

endmodule

// ===== tb/sv/nfbm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfbm_checker
// Watches the config port and both streams of the NFA full matcher, keeps its
// own copy of the NFA table, class bitmaps and active set, predicts the
// alive / accepting / last answer of every byte or final begin and compares it in order.
// ----------------------------------------------------------------------------
module nfbm_checker
	import nfbm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	input  logic         m_tlast,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic alive;
		logic accepting;
		logic fin;
	} answer_t;

	// predicted registers
	logic [6:0]   start_r;
	logic [7:0]   count_r;
	logic         pvalid_r;

	// predicted NFA store
	kind_t        tk[128];
	logic [7:0]   ts1[128];
	logic [7:0]   ts2[128];
	logic [7:0]   tbyte[128];
	logic [5:0]   tcref[128];
	logic         tneg[128];
	logic [63:0]  cmap[256];
	logic [127:0] act;
	logic         dead;

	answer_t      answer_q[$];

	function automatic int live_n();
		return (count_r > 8'd128) ? 128 : int'(count_r);
	endfunction

	function automatic logic set_alive(logic [127:0] set);
		int i;
		for (i = 0; i < live_n(); i++)
			if (set[i]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic set_accepts(logic [127:0] set);
		int i;
		for (i = 0; i < live_n(); i++)
			if (set[i] && tk[i] == KIND_MATCH) return 1'b1;
		return 1'b0;
	endfunction

	// add the epsilon closure of one successor code to a set
	function automatic logic [127:0] with_closure(logic [127:0] set, logic [7:0] code);
		int stk[128];
		int depth;
		int s;
		int k;
		logic [7:0] c;
		int n;
		n = live_n();
		depth = 0;
		if (code[7] || int'(code) >= n || set[code]) return set;
		set[code] = 1'b1;
		stk[depth] = int'(code);
		depth++;
		while (depth > 0) begin
			depth--;
			s = stk[depth];
			if (tk[s] == KIND_SPLIT) begin
				for (k = 0; k < 2; k++) begin
					c = (k == 0) ? ts1[s] : ts2[s];
					if (!c[7] && int'(c) < n && !set[c] && depth < 128) begin
						set[c] = 1'b1;
						stk[depth] = int'(c);
						depth++;
					end
				end
			end
		end
		return set;
	endfunction

	// apply one accepted item to the predicted matcher
	task automatic step_matcher(input mode_t md, input logic [111:0] d, input logic lst);
		logic [6:0]   idx;
		logic [7:0]   b;
		logic [127:0] nxt;
		logic         hit;
		int           i;
		answer_t      a;
		idx = d[6:0];
		b   = d[32:25];
		case (md)
			MODE_LOAD_STATE: begin
				tk[idx]    = kind_t'(d[8:7]);
				ts1[idx]   = d[16:9];
				ts2[idx]   = d[24:17];
				tbyte[idx] = b;
				tcref[idx] = d[38:33];
				tneg[idx]  = d[39];
			end
			MODE_LOAD_CLASS: begin
				if (idx < 7'd64) cmap[{idx[5:0], d[41:40]}] = d[105:42];
			end
			default: begin
				if (md == MODE_BEGIN) begin
					act  = with_closure('0, {1'b0, start_r});
					dead = !set_alive(act);
				end else if (!dead) begin
					nxt = '0;
					for (i = 0; i < live_n(); i++) begin
						if (act[i]) begin
							hit = 1'b0;
							if (tk[i] == KIND_CHAR)
								hit = (tbyte[i] == b);
							else if (tk[i] == KIND_CLASS)
								hit = cmap[{tcref[i], b[7:6]}][b[5:0]] ^ tneg[i];
							if (hit) nxt = with_closure(nxt, ts1[i]);
						end
					end
					act  = nxt;
					dead = !set_alive(act);
					if (dead) act = '0;
				end
				if (md == MODE_DATA || lst) begin
					a.alive     = !dead && set_alive(act);
					a.accepting = pvalid_r && a.alive && set_accepts(act);
					a.fin       = lst;
					answer_q = {answer_q, a};
				end
			end
		endcase
	endtask

	// watch config writes, items in and results out
	always @(posedge clk or negedge arst_n) begin
		answer_t w;
		int      bad;
		bad = 0;
		if (!arst_n) begin
			start_r  <= '0;
			count_r  <= '0;
			pvalid_r <= 1'b0;
			act      = '0;
			dead     = 1'b1;
			errors   <= 0;
			answer_q.delete();
			pending  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_STATE:   start_r  <= cfg_wdata[6:0];
					CFG_STATE_COUNT:   count_r  <= cfg_wdata;
					CFG_PATTERN_VALID: pvalid_r <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				step_matcher(mode_t'(s_tuser), s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					$error("unexpected result: alive=%0b accepting=%0b last=%0b",
						m_tdata[0], m_tdata[1], m_tlast);
					bad++;
				end else begin
					w = answer_q.pop_front();
					if (m_tdata[0] !== w.alive) begin
						$error("alive: expected %0b, got %0b", w.alive, m_tdata[0]);
						bad++;
					end
					if (m_tdata[1] !== w.accepting) begin
						$error("accepting: expected %0b, got %0b", w.accepting, m_tdata[1]);
						bad++;
					end
					if (m_tlast !== w.fin) begin
						$error("final_res: expected %0b, got %0b", w.fin, m_tlast);
						bad++;
					end
				end
			end
			errors  <= errors + bad;
			pending <= answer_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the NFA full matcher: loads random NFAs, mostly small (and one
// directed full size table), runs strings over them with random stalls on both
// streams and leaves all checking to nfbm_checker.
// ----------------------------------------------------------------------------
module tb;
	import nfbm_pkg::*;

	localparam int QUIET_LIMIT = 40000;
	localparam int SETTLE      = 2000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [7:0]   cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;
	logic         m_tlast;
	int           errors;
	int           pending;
	int           quiet;
	int           sent;
	logic         busy_src;
	logic         busy_snk;
	logic [63:0]  cls_ok;
	logic [7:0]   alpha[$];

	nfa_byte_full_matcher uut (.*);

	nfbm_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly none, some short, a few long
	function automatic int gap_len(logic busy);
		int r;
		r = $urandom_range(0, 99);
		if (busy || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side stalls
	always @(posedge clk) begin
		int g;
		g = gap_len(busy_snk);
		m_tready <= (g == 0);
		if (g > 3) begin
			repeat (g) @(posedge clk);
			m_tready <= 1'b1;
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic put(input mode_t md, input logic [111:0] d, input logic lst);
		int g;
		g = gap_len(busy_src);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= d;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	function automatic logic [111:0] pack(logic [6:0] idx, kind_t k, logic [7:0] s1,
		logic [7:0] s2, logic [7:0] b, logic [5:0] cref, logic neg, logic [1:0] ws,
		logic [63:0] bits);
		return {6'b0, bits, ws, neg, cref, b, s2, s1, k, idx};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// wait out every pending result and any work that gives none
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input logic [6:0] st, input logic [7:0] cnt, input logic pv);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_STATE;
		cfg_wdata <= {1'b0, st};
		@(posedge clk);
		cfg_index <= CFG_STATE_COUNT;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_index <= CFG_PATTERN_VALID;
		cfg_wdata <= {7'b0, pv};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// full 256-bit class bitmap, or noise at an ignored class index
	task automatic load_class(input logic [6:0] ci);
		int q;
		for (q = 0; q < 4; q++)
			put(MODE_LOAD_CLASS, pack(ci, KIND_CHAR, '0, '0, '0, '0, 1'b0, q[1:0],
				(q == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64()), 1'b0);
		if (ci < 7'd64) cls_ok[ci[5:0]] = 1'b1;
	endtask

	function automatic logic [7:0] pick_succ(int n);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'hFF;
		if (r < 16 || n == 0) return 8'($urandom_range(0, 127));
		return 8'($urandom_range(0, n - 1));
	endfunction

	// load states 0..n-1 with a random NFA
	task automatic load_nfa(input int n);
		int i;
		kind_t k;
		logic [5:0] cref;
		logic [7:0] b;
		for (i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 3));
			if ($urandom_range(0, 3) == 0) k = KIND_SPLIT;
			do cref = 6'($urandom_range(0, 63)); while (!cls_ok[cref]);
			b = alpha[$urandom_range(0, alpha.size() - 1)];
			put(MODE_LOAD_STATE, pack(7'(i), k, pick_succ(n), pick_succ(n), b, cref,
				1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand64()), 1'b0);
		end
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 9) < 7) return alpha[$urandom_range(0, alpha.size() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	// a begin and a string of bytes, last marked
	task automatic run_string(input int len);
		int j;
		put(MODE_BEGIN, pack(7'($urandom_range(0, 127)), KIND_CHAR, '0, '0,
			8'($urandom_range(0, 255)), '0, 1'b0, '0, rand64()), len == 0);
		for (j = 0; j < len; j++)
			put(MODE_DATA, pack('0, KIND_CHAR, '0, '0, pick_byte(), '0, 1'b0, '0, '0),
				j == len - 1);
		// bytes past the last keep stepping
		if ($urandom_range(0, 5) == 0)
			put(MODE_DATA, pack('0, KIND_CHAR, '0, '0, pick_byte(), '0, 1'b0, '0, '0),
				1'($urandom_range(0, 1)));
	endtask

	task automatic phase(input int n, input logic [6:0] st, input logic pv, input int strs);
		int j;
		drain();
		set_regs(st, 8'(n), pv);
		busy_src = ($urandom_range(0, 3) == 0);
		busy_snk = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 2) == 0) load_class(7'($urandom_range(0, 63)));
		if ($urandom_range(0, 4) == 0) load_class(7'($urandom_range(64, 127)));
		load_nfa(n);
		for (j = 0; j < strs; j++) run_string($urandom_range(0, 8));
	endtask

	initial begin
		int n;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_START_STATE;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_LOAD_STATE;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		quiet     = 0;
		sent      = 0;
		busy_src  = 1'b0;
		busy_snk  = 1'b0;
		cls_ok    = '0;
		alpha     = '{8'h00, 8'hFF, 8'h61, 8'h62, 8'h7F, 8'h80};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme classes, empty table, full size table, start out of range, pattern not valid
		load_class(7'd0);
		load_class(7'd63);
		load_class(7'd127);
		phase(0, 7'd0, 1'b1, 2);
		phase(128, 7'd127, 1'b1, 3);
		phase(4, 7'd100, 1'b1, 1);
		phase(3, 7'd0, 1'b0, 2);

		// random NFAs and strings
		while (sent < 900) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 128) : $urandom_range(1, 12);
			phase(n, ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
				7'($urandom_range(0, n - 1)), $urandom_range(0, 4) != 0, $urandom_range(4, 10));
		end

		drain();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
